/* rtl/icmp_er_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_er_pkg
// shared types, constants and checksum arithmetic of the icmp echo responder
// ----------------------------------------------------------------------------
package icmp_er_pkg;

	localparam int BUF_BYTES = 2048;
	localparam int BUF_AW    = $clog2(BUF_BYTES);
	localparam int CNT_W     = BUF_AW + 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [CNT_W-1:0] BUF_CNT   = CNT_W'(BUF_BYTES);
	localparam logic [CNT_W-1:0] MIN_LEN   = CNT_W'(28);
	localparam logic [CNT_W-1:0] ICMP_HDR  = CNT_W'(8);
	localparam logic [CNT_W-1:0] POS_PROTO = CNT_W'(9);
	localparam logic [CNT_W-1:0] POS_CK_HI = CNT_W'(10);
	localparam logic [CNT_W-1:0] POS_CK_LO = CNT_W'(11);
	localparam logic [CNT_W-1:0] POS_SRC   = CNT_W'(12);
	localparam logic [CNT_W-1:0] POS_DST   = CNT_W'(16);
	localparam logic [CNT_W-1:0] POS_AEND  = CNT_W'(20);
	localparam logic [CNT_W-1:0] ADDR_LEN  = CNT_W'(4);
	localparam logic [CNT_W-1:0] OFS_CK_HI = CNT_W'(2);
	localparam logic [CNT_W-1:0] OFS_CK_LO = CNT_W'(3);

	localparam logic [3:0] IP_VERSION    = 4'd4;
	localparam logic [3:0] MIN_IHL       = 4'd5;
	localparam logic [7:0] PROTO_ICMP    = 8'd1;
	localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PULL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		OUT_BYTE  = 3'd0,
		OUT_READY = 3'd1,
		OUT_DROP  = 3'd2,
		OUT_OVFL  = 3'd3,
		OUT_NONE  = 3'd4
	} outcome_t;

	typedef enum logic {
		ST_RUN  = 1'b0,
		ST_READ = 1'b1
	} bk_state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       last;
	} item_t;

	function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, v};
		return t[16] ? (t[15:0] + 16'd1) : t[15:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/icmp_er_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_er_front
// input side: takes stream transfers, classifies them and queues them
// ----------------------------------------------------------------------------
module icmp_er_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire  [7:0]           s_axis_tdata,  // [7:0] data_byte
	input  wire                  s_axis_tlast,
	input  wire  [0:0]           s_axis_tuser,  // [0] cmd
	output logic                 head_valid,
	output icmp_er_pkg::item_t   head,
	input  wire                  pop
);

	icmp_er_pkg::item_t                 q_q [icmp_er_pkg::Q_DEPTH];
	logic [icmp_er_pkg::Q_AW-1:0]       wptr_q;
	logic [icmp_er_pkg::Q_AW-1:0]       rptr_q;
	logic [icmp_er_pkg::Q_AW:0]         cnt_q;
	logic                               push;
	logic                               do_pop;
	icmp_er_pkg::item_t                 in_item;

	always_comb begin
		in_item.op   = s_axis_tuser[0] ? icmp_er_pkg::OP_PULL : icmp_er_pkg::OP_LOAD;
		in_item.data = s_axis_tdata;
		in_item.last = s_axis_tlast;
	end

	assign s_axis_tready = (cnt_q != (icmp_er_pkg::Q_AW+1)'(icmp_er_pkg::Q_DEPTH));
	assign push          = s_axis_tvalid & s_axis_tready;
	assign head_valid    = (cnt_q != '0);
	assign do_pop        = pop & head_valid;
	assign head          = q_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/icmp_er_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_er_back
// packet store, running checksums, packet check and reply readout
// ----------------------------------------------------------------------------
module icmp_er_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  icmp_er_pkg::item_t  head,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
	output logic                m_axis_tlast,
	output logic [2:0]          m_axis_tuser   // [2:0] outcome
);

	localparam int AW = icmp_er_pkg::BUF_AW;
	localparam int CW = icmp_er_pkg::CNT_W;

	logic [7:0]                 store_q [icmp_er_pkg::BUF_BYTES];
	logic [7:0]                 rdata_q;

	icmp_er_pkg::bk_state_t     st_q, st_d;
	logic [CW-1:0]              wc_q, wc_d;
	logic [CW-1:0]              ri_q, ri_d;
	logic [3:0]                 hw_q, hw_d;
	logic [15:0]                hs_q, hs_d;
	logic [15:0]                ms_q, ms_d;
	logic                       ovf_q, ovf_d;
	logic                       pend_q, pend_d;
	logic [3:0]                 ver_q, ver_d;
	logic [7:0]                 proto_q, proto_d;
	logic [7:0]                 typ_q, typ_d;

	logic                       outv_q;
	logic [7:0]                 outbyte_q;
	logic                       outlast_q;
	icmp_er_pkg::outcome_t      outcode_q;
	logic                       out_free;

	logic                       res_v;
	logic [7:0]                 res_byte;
	logic                       res_last;
	icmp_er_pkg::outcome_t      res_code;

	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              raddr;

	// load path
	logic [CW-1:0]              b_wc, l_wc, p, h, h_acc;
	logic [3:0]                 b_hw, l_hw;
	logic [15:0]                b_hs, b_ms, l_hs, l_ms, v;
	logic                       b_ovf, l_ovf, l_we, l_ok;
	logic [3:0]                 l_ver;
	logic [7:0]                 l_proto, l_typ;

	// readout path
	logic [CW-1:0]              h_cur, rd_src;
	logic [15:0]                ipck, icck;
	logic [7:0]                 rep_byte;
	logic                       rd_last;

	assign out_free = !outv_q || m_axis_tready;

	always_comb begin
		b_wc  = pend_q ? '0 : wc_q;
		b_hw  = pend_q ? '0 : hw_q;
		b_hs  = pend_q ? '0 : hs_q;
		b_ms  = pend_q ? '0 : ms_q;
		b_ovf = pend_q ? 1'b0 : ovf_q;
		p       = b_wc;
		l_wc    = b_wc;
		l_hw    = b_hw;
		l_hs    = b_hs;
		l_ms    = b_ms;
		l_ovf   = b_ovf;
		l_we    = 1'b0;
		l_ver   = ver_q;
		l_proto = proto_q;
		l_typ   = typ_q;
		h       = CW'({b_hw, 2'b00});
		v       = p[0] ? {8'h00, head.data} : {head.data, 8'h00};
		if (!b_ovf) begin
			if (p < icmp_er_pkg::BUF_CNT) begin
				l_we = 1'b1;
				l_wc = p + CW'(1);
				if (p == '0) begin
					l_hw  = head.data[3:0];
					l_ver = head.data[7:4];
				end
				h = CW'({l_hw, 2'b00});
				if (p < h) begin
					if (p != icmp_er_pkg::POS_CK_HI && p != icmp_er_pkg::POS_CK_LO) begin
						l_hs = icmp_er_pkg::ones_add(b_hs, v);
					end
				end else if (p != h && p != h + icmp_er_pkg::OFS_CK_HI
						&& p != h + icmp_er_pkg::OFS_CK_LO) begin
					l_ms = icmp_er_pkg::ones_add(b_ms, v);
				end
				if (p == icmp_er_pkg::POS_PROTO) begin
					l_proto = head.data;
				end
				if (p == h) begin
					l_typ = head.data;
				end
			end else begin
				l_ovf = 1'b1;
			end
		end
		h_acc = CW'({l_hw, 2'b00});
		l_ok  = (l_wc >= icmp_er_pkg::MIN_LEN) && (l_ver == icmp_er_pkg::IP_VERSION)
			&& (l_hw >= icmp_er_pkg::MIN_IHL) && (l_proto == icmp_er_pkg::PROTO_ICMP)
			&& (l_wc >= h_acc + icmp_er_pkg::ICMP_HDR)
			&& (l_typ == icmp_er_pkg::ICMP_ECHO_REQ);
	end

	always_comb begin
		h_cur = CW'({hw_q, 2'b00});
		ipck  = ~hs_q;
		icck  = ~ms_q;
		if (ri_q >= icmp_er_pkg::POS_SRC && ri_q < icmp_er_pkg::POS_DST) begin
			rd_src = ri_q + icmp_er_pkg::ADDR_LEN;
		end else if (ri_q >= icmp_er_pkg::POS_DST && ri_q < icmp_er_pkg::POS_AEND) begin
			rd_src = ri_q - icmp_er_pkg::ADDR_LEN;
		end else begin
			rd_src = ri_q;
		end
		if (ri_q == icmp_er_pkg::POS_CK_HI) begin
			rep_byte = ipck[15:8];
		end else if (ri_q == icmp_er_pkg::POS_CK_LO) begin
			rep_byte = ipck[7:0];
		end else if (ri_q >= icmp_er_pkg::POS_SRC && ri_q < icmp_er_pkg::POS_AEND) begin
			rep_byte = rdata_q;
		end else if (ri_q == h_cur) begin
			rep_byte = 8'h00;
		end else if (ri_q == h_cur + icmp_er_pkg::OFS_CK_HI) begin
			rep_byte = icck[15:8];
		end else if (ri_q == h_cur + icmp_er_pkg::OFS_CK_LO) begin
			rep_byte = icck[7:0];
		end else begin
			rep_byte = rdata_q;
		end
		rd_last = ((ri_q + CW'(1)) >= wc_q);
	end

	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		raddr    = rd_src[AW-1:0];
		wc_d     = wc_q;
		ri_d     = ri_q;
		hw_d     = hw_q;
		hs_d     = hs_q;
		ms_d     = ms_q;
		ovf_d    = ovf_q;
		pend_d   = pend_q;
		ver_d    = ver_q;
		proto_d  = proto_q;
		typ_d    = typ_q;
		res_v    = 1'b0;
		res_byte = 8'h00;
		res_last = 1'b0;
		res_code = icmp_er_pkg::OUT_NONE;
		case (st_q)
			icmp_er_pkg::ST_RUN: begin
				if (head_valid) begin
					if (head.op == icmp_er_pkg::OP_PULL) begin
						if (!pend_q) begin
							if (out_free) begin
								res_v    = 1'b1;
								res_code = icmp_er_pkg::OUT_NONE;
								pop      = 1'b1;
							end
						end else begin
							mem_re = 1'b1;
							st_d   = icmp_er_pkg::ST_READ;
						end
					end else if (!head.last || out_free) begin
						pop     = 1'b1;
						mem_we  = l_we;
						wc_d    = l_wc;
						ri_d    = pend_q ? '0 : ri_q;
						hw_d    = l_hw;
						hs_d    = l_hs;
						ms_d    = l_ms;
						ovf_d   = l_ovf;
						pend_d  = 1'b0;
						ver_d   = l_ver;
						proto_d = l_proto;
						typ_d   = l_typ;
						if (head.last) begin
							res_v = 1'b1;
							if (!l_ovf && l_ok) begin
								pend_d   = 1'b1;
								ri_d     = '0;
								res_code = icmp_er_pkg::OUT_READY;
							end else begin
								wc_d     = '0;
								ri_d     = '0;
								hw_d     = '0;
								hs_d     = '0;
								ms_d     = '0;
								ovf_d    = 1'b0;
								res_code = l_ovf ? icmp_er_pkg::OUT_OVFL
									: icmp_er_pkg::OUT_DROP;
							end
						end
					end
				end
			end
			icmp_er_pkg::ST_READ: begin
				if (out_free) begin
					res_v    = 1'b1;
					res_code = icmp_er_pkg::OUT_BYTE;
					res_byte = rep_byte;
					res_last = rd_last;
					pop      = 1'b1;
					st_d     = icmp_er_pkg::ST_RUN;
					if (rd_last) begin
						wc_d   = '0;
						ri_d   = '0;
						hw_d   = '0;
						hs_d   = '0;
						ms_d   = '0;
						ovf_d  = 1'b0;
						pend_d = 1'b0;
					end else begin
						ri_d = ri_q + CW'(1);
					end
				end
			end
			default: begin
				st_d = icmp_er_pkg::ST_RUN;
			end
		endcase
	end

	// packet store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[p[AW-1:0]] <= head.data;
		end
		if (mem_re) begin
			rdata_q <= store_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= icmp_er_pkg::ST_RUN;
			wc_q   <= '0;
			ri_q   <= '0;
			hw_q   <= '0;
			hs_q   <= '0;
			ms_q   <= '0;
			ovf_q  <= 1'b0;
			pend_q <= 1'b0;
			outv_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			wc_q   <= wc_d;
			ri_q   <= ri_d;
			hw_q   <= hw_d;
			hs_q   <= hs_d;
			ms_q   <= ms_d;
			ovf_q  <= ovf_d;
			pend_q <= pend_d;
			if (res_v) begin
				outv_q <= 1'b1;
			end else if (m_axis_tready) begin
				outv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ver_q   <= ver_d;
		proto_q <= proto_d;
		typ_q   <= typ_d;
		if (res_v) begin
			outbyte_q <= res_byte;
			outlast_q <= res_last;
			outcode_q <= res_code;
		end
	end

	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata  = outbyte_q;
	assign m_axis_tlast  = outlast_q;
	assign m_axis_tuser  = outcode_q;

	a_pend_len: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (wc_q >= icmp_er_pkg::MIN_LEN))
		else $error("reply pending on a short packet");

	a_read_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == icmp_er_pkg::ST_READ) |-> pend_q)
		else $error("readout without a pending reply");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (wc_q == icmp_er_pkg::BUF_CNT))
		else $error("overflow flagged before the store is full");

	a_ri_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (ri_q < wc_q))
		else $error("read index past the packet end");

endmodule
`default_nettype wire

/* rtl/icmp_echo_responder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// icmp_echo_responder_unit
// ipv4 icmp echo responder: buffers a packet, checks it, reads back the reply
// ----------------------------------------------------------------------------
// s_axis carries one command per transfer: tuser[0] = 0 loads tdata as the next
// packet byte (tlast marks the final byte), tuser[0] = 1 pulls one reply byte.
// m_axis returns at most one transfer per command: tdata is the reply byte,
// tlast marks the final reply byte, tuser is the outcome code (reply byte,
// reply ready, dropped, overflow dropped, nothing pending). a load that is not
// the final byte returns nothing.
// a 4-entry command queue sits in front of the engine. loads and idle pulls
// stream at one per cycle, a final load or idle pull only when the output
// register is free; a reply byte pull also passes the read state, set by the
// registered read port of the packet store, before the next command. a result
// passes the queue, the read state for a reply byte, and the output register.
// reset clears the queue, counters, sums and the output register; the packet
// store is not cleared. when m_axis stalls the output register holds, the
// engine stops at the next command that produces a result, and s_axis_tready
// drops once the queue is full.
// ----------------------------------------------------------------------------
module icmp_echo_responder_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire        s_axis_tlast,
	input  wire  [0:0] s_axis_tuser,   // [0] cmd
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic [2:0] m_axis_tuser    // [2:0] outcome
);

	logic                head_valid;
	icmp_er_pkg::item_t  head;
	logic                pop;

	icmp_er_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop)
	);

	icmp_er_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

/* verif/tb_icmp_echo_responder_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_icmp_echo_responder_unit
// self-checking bench: streams load and pull commands, predicts every reply
// ----------------------------------------------------------------------------
// commands sit in a queue that the stimulus block fills and a clocked driver
// empties onto s_axis. each accepted command goes through an in-bench echo
// responder predictor that keeps its own packet copy, running header and icmp
// sums and reply position. a clocked monitor compares every m_axis transfer
// with the oldest predicted one. stimulus: a few corner commands, then mostly
// well-formed echo requests with random content and readout, broken headers
// and mixed noise.
// ----------------------------------------------------------------------------
module tb_icmp_echo_responder_unit;
	import icmp_er_pkg::*;

	localparam int IDLE_PCT     = 16;
	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1380;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		outcome_t   code;
	} echo_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	wire        s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic       s_axis_tlast = 1'b0;
	logic [0:0] s_axis_tuser = 1'b0;    // [0] cmd
	wire        m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	wire  [7:0] m_axis_tdata;           // [7:0] out_byte
	wire        m_axis_tlast;
	wire  [2:0] m_axis_tuser;           // [2:0] outcome

	icmp_echo_responder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	item_t       pending_cmds [$];
	echo_out_t   awaited_out [$];
	logic [7:0]  pkt_buf [$];
	item_t       drv_next;
	item_t       drv_seen;
	echo_out_t   mon_want;
	int          err_count = 0;
	int          cmds_in = 0;
	int          outs_seen = 0;
	int          stim_items = 0;
	int          seen_outcome [5] = '{default: 0};
	int          cyc = 0;
	int          stuck = 0;
	logic        calm;

	// echo responder predictor state
	logic [7:0]  pkt_copy [0:BUF_BYTES-1];
	int unsigned pkt_len = 0;
	int unsigned rd_pos = 0;
	logic [3:0]  ihl_seen = 4'd0;
	logic [15:0] hdr_csum = 16'h0000;
	logic [15:0] icmp_csum = 16'h0000;
	bit          over_full = 1'b0;
	bit          echo_ready = 1'b0;

	assign calm = (cyc % 2500) < 500;

	initial forever #5 clk = ~clk;

	function automatic logic [15:0] csum_fold(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] t;
		t = {1'b0, acc} + {1'b0, word};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	function automatic void forget_packet();
		pkt_len = 0;
		rd_pos = 0;
		ihl_seen = 4'd0;
		hdr_csum = 16'h0000;
		icmp_csum = 16'h0000;
		over_full = 1'b0;
		echo_ready = 1'b0;
	endfunction

	function automatic bit is_echo_request();
		int unsigned hlen;
		hlen = 4 * int'(ihl_seen);
		if (pkt_len < 28) return 1'b0;
		if (pkt_copy[0][7:4] != IP_VERSION) return 1'b0;
		if (ihl_seen < MIN_IHL) return 1'b0;
		if (pkt_copy[9] != PROTO_ICMP) return 1'b0;
		if (pkt_len < hlen + 8) return 1'b0;
		return pkt_copy[hlen] == ICMP_ECHO_REQ;
	endfunction

	function automatic logic [7:0] reply_byte_at(input int unsigned idx);
		int unsigned hlen;
		logic [15:0] ip_ck;
		logic [15:0] icmp_ck;
		hlen = 4 * int'(ihl_seen);
		ip_ck = ~hdr_csum;
		icmp_ck = ~icmp_csum;
		if (idx == 10) return ip_ck[15:8];
		if (idx == 11) return ip_ck[7:0];
		if (idx >= 12 && idx < 16) return pkt_copy[idx + 4];
		if (idx >= 16 && idx < 20) return pkt_copy[idx - 4];
		if (idx == hlen) return ICMP_ECHO_REPLY;
		if (idx == hlen + 2) return icmp_ck[15:8];
		if (idx == hlen + 3) return icmp_ck[7:0];
		return pkt_copy[idx];
	endfunction

	task automatic echo_predict(input item_t it);
		echo_out_t   r;
		int unsigned pos;
		int unsigned hlen;
		int unsigned ofs;
		logic [15:0] word;
		r.data = 8'h00;
		r.last = 1'b0;
		r.code = OUT_NONE;
		if (it.op == OP_PULL) begin
			if (echo_ready && rd_pos < pkt_len) begin
				r.data = reply_byte_at(rd_pos);
				r.code = OUT_BYTE;
				if (rd_pos + 1 >= pkt_len) begin
					r.last = 1'b1;
					forget_packet();
				end else begin
					rd_pos++;
				end
			end
			awaited_out.push_back(r);
		end else begin
			if (echo_ready) forget_packet();
			if (!over_full) begin
				if (pkt_len < BUF_BYTES) begin
					pos = pkt_len;
					pkt_copy[pos] = it.data;
					pkt_len = pos + 1;
					if (pos == 0) ihl_seen = it.data[3:0];
					hlen = 4 * int'(ihl_seen);
					word = pos[0] ? {8'h00, it.data} : {it.data, 8'h00};
					if (pos < hlen) begin
						if (pos != 10 && pos != 11) hdr_csum = csum_fold(hdr_csum, word);
					end else begin
						ofs = pos - hlen;
						if (ofs != 0 && ofs != 2 && ofs != 3) icmp_csum = csum_fold(icmp_csum, word);
					end
				end else begin
					over_full = 1'b1;
				end
			end
			if (it.last) begin
				if (over_full) begin
					forget_packet();
					r.code = OUT_OVFL;
				end else if (is_echo_request()) begin
					echo_ready = 1'b1;
					rd_pos = 0;
					r.code = OUT_READY;
				end else begin
					forget_packet();
					r.code = OUT_DROP;
				end
				awaited_out.push_back(r);
			end
		end
	endtask

	task automatic report_err(input string msg);
		err_count++;
		if (err_count <= 40) $display("ERROR %0t: %s", $time, msg);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				drv_seen.op = op_t'(s_axis_tuser[0]);
				drv_seen.data = s_axis_tdata;
				drv_seen.last = s_axis_tlast;
				echo_predict(drv_seen);
				cmds_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					drv_next = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= drv_next.op;
					s_axis_tdata <= drv_next.data;
					s_axis_tlast <= drv_next.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				outs_seen++;
				if (awaited_out.size() == 0) begin
					report_err($sformatf("unexpected transfer data %02h last %0d outcome %0d",
						m_axis_tdata, m_axis_tlast, m_axis_tuser));
				end else begin
					mon_want = awaited_out.pop_front();
					seen_outcome[int'(mon_want.code)]++;
					if (m_axis_tuser !== mon_want.code)
						report_err($sformatf("transfer %0d: outcome %0d, want %0d",
							outs_seen, m_axis_tuser, mon_want.code));
					if (m_axis_tdata !== mon_want.data)
						report_err($sformatf("transfer %0d: data %02h, want %02h",
							outs_seen, m_axis_tdata, mon_want.data));
					if (m_axis_tlast !== mon_want.last)
						report_err($sformatf("transfer %0d: last %0d, want %0d",
							outs_seen, m_axis_tlast, mon_want.last));
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			cyc <= cyc + 1;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stuck <= 0;
			end else if (stuck >= STALL_LIMIT) begin
				$display("ERROR %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				stuck <= stuck + 1;
			end
		end
	end

	task automatic push_cmd(input op_t op, input logic [7:0] d, input logic l);
		item_t it;
		it.op = op;
		it.data = d;
		it.last = l;
		pending_cmds.push_back(it);
		stim_items++;
	endtask

	task automatic push_pulls(input int n);
		int k;
		for (k = 0; k < n; k++) push_cmd(OP_PULL, 8'($urandom), 1'($urandom));
	endtask

	task automatic push_packet();
		int k;
		for (k = 0; k < pkt_buf.size(); k++)
			push_cmd(OP_LOAD, pkt_buf[k], k == pkt_buf.size() - 1);
	endtask

	task automatic make_random(input int len);
		int k;
		pkt_buf.delete();
		for (k = 0; k < len; k++) pkt_buf.push_back(8'($urandom));
	endtask

	task automatic make_echo(input int ihl, input int len);
		make_random(len);
		pkt_buf[0] = {IP_VERSION, 4'(ihl)};
		pkt_buf[9] = PROTO_ICMP;
		if (ihl * 4 < len) pkt_buf[ihl * 4] = ICMP_ECHO_REQ;
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || s_axis_tvalid || awaited_out.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int sel;
		int ihl;
		int len;
		int k;
		int stop_at;
		logic [3:0] bad_ver;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner commands: idle pulls, one- and two-byte packets, a minimal echo read back
		push_cmd(OP_PULL, 8'hFF, 1'b1);
		push_cmd(OP_PULL, 8'h00, 1'b0);
		push_cmd(OP_LOAD, 8'hFF, 1'b1);
		push_cmd(OP_LOAD, 8'h00, 1'b0);
		push_cmd(OP_LOAD, 8'h45, 1'b1);
		push_cmd(OP_PULL, 8'hA5, 1'b0);
		make_echo(5, 28);
		push_packet();
		push_pulls(29);
		wait_quiet();

		stop_at = stim_items + RANDOM_ITEMS;
		while (stim_items < stop_at) begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 6) : 5;
				len = (ihl * 4 + 8 > 28) ? ihl * 4 + 8 : 28;
				len += ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(12);
				make_echo(ihl, len);
				push_packet();
				if ($urandom_range(9) == 0) push_pulls($urandom_range(len - 1));
				else push_pulls(len + $urandom_range(2));
			end else if (sel < 85) begin
				case ($urandom_range(5))
					0: begin
						make_echo(5, 28 + $urandom_range(10));
						bad_ver = 4'($urandom_range(15));
						if (bad_ver == IP_VERSION) bad_ver = ~bad_ver;
						pkt_buf[0] = {bad_ver, pkt_buf[0][3:0]};
					end
					1: begin
						make_echo(5, 28 + $urandom_range(10));
						pkt_buf[0] = {IP_VERSION, 4'($urandom_range(4))};
					end
					2: begin
						make_echo(5, 28 + $urandom_range(10));
						pkt_buf[9] = PROTO_ICMP ^ 8'($urandom_range(1, 255));
					end
					3: begin
						ihl = $urandom_range(15, 5);
						make_echo(ihl, ihl * 4 + 8 + $urandom_range(6));
						pkt_buf[ihl * 4] = ICMP_ECHO_REQ ^ 8'($urandom_range(1, 255));
					end
					4: begin
						len = $urandom_range(27, 1);
						make_random(len);
						pkt_buf[0] = {IP_VERSION, MIN_IHL};
						if (len > 9) pkt_buf[9] = PROTO_ICMP;
						if (len > 20) pkt_buf[20] = ICMP_ECHO_REQ;
					end
					default: begin
						ihl = $urandom_range(15, 6);
						make_echo(ihl, $urandom_range(ihl * 4 + 7, 28));
					end
				endcase
				push_packet();
				push_pulls($urandom_range(2));
			end else begin
				// mixed loads and pulls, closed by a final load
				len = $urandom_range(40, 1);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(9) < 3) push_pulls(1);
					else push_cmd(OP_LOAD, 8'($urandom), $urandom_range(9) == 0);
				end
				push_cmd(OP_LOAD, 8'($urandom), 1'b1);
				push_pulls($urandom_range(3));
			end
			if ($urandom_range(19) == 0) wait_quiet();
		end
		wait_quiet();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d command transfers in, %0d result transfers out", cmds_in, outs_seen);
		$display("summary: %0d reply bytes, %0d ready, %0d dropped, %0d overflow, %0d idle pulls",
			seen_outcome[OUT_BYTE], seen_outcome[OUT_READY], seen_outcome[OUT_DROP],
			seen_outcome[OUT_OVFL], seen_outcome[OUT_NONE]);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
